/* sv/pfa_pkg.sv */
package pfa_pkg;

   // fixed field widths
   localparam int KIND_W     = 1;
   localparam int INDEX_W    = 4;
   localparam int AMOUNT_W   = 16;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // search policies
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS = 1'b1;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

   localparam logic [COUNT_W-1:0] NUM_BLOCKS_RESET = 5'd16;

   typedef struct packed {
      logic load_wr;   // write a capacity from the accepted request
      logic start;     // latch the accepted allocation request
      logic scan;      // advance the table scan
      logic finish;    // write back and present the response
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctl_sts_type;

endpackage

/* sv/pfa_req_if.sv */
interface pfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [pfa_pkg::KIND_W-1:0]     kind;
   logic [pfa_pkg::INDEX_W-1:0]    block_index;
   logic [pfa_pkg::AMOUNT_W-1:0]   amount;

   modport source (output valid, kind, block_index, amount, input ready);
   modport sink   (input valid, kind, block_index, amount, output ready);
endinterface

/* sv/pfa_rsp_if.sv */
interface pfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           granted;
   logic [pfa_pkg::INDEX_W-1:0]    chosen_index;
   logic [pfa_pkg::AMOUNT_W-1:0]   capacity_left;

   modport source (output valid, granted, chosen_index, capacity_left, input ready);
   modport sink   (input valid, granted, chosen_index, capacity_left, output ready);
endinterface

/* sv/pfa_ram.sv */
module pfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pfa_ctrl.sv */
module pfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [pfa_pkg::KIND_W-1:0] req_kind,
   output logic                  req_ready,
   input  pfa_pkg::ctl_sts_type  sts,
   output pfa_pkg::ctl_cmd_type  cmd
);
   import pfa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* sv/pfa_datapath.sv */
module pfa_datapath #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic [pfa_pkg::INDEX_W-1:0]      req_block_index,
   input  logic [pfa_pkg::AMOUNT_W-1:0]     req_amount,
   input  pfa_pkg::ctl_cmd_type             cmd,
   output pfa_pkg::ctl_sts_type             sts,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_granted,
   output logic [pfa_pkg::INDEX_W-1:0]      rsp_chosen_index,
   output logic [pfa_pkg::AMOUNT_W-1:0]     rsp_capacity_left
);
   import pfa_pkg::*;

   localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

   logic [MODE_W-1:0]    fit_mode_ff;
   logic [COUNT_W-1:0]   num_blocks_ff;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [SIZE_BITS-1:0] amt_ff, amt_in;
   logic                 found_ff, found_in;
   logic [ADDR_W-1:0]    pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [AMOUNT_W-1:0]  rsp_cap_ff;

   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [SIZE_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] new_cap;
   logic                 fits;
   logic                 take;
   logic                 load_in_range;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= FIT_FIRST;
         num_blocks_ff <= NUM_BLOCKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIT_MODE:   fit_mode_ff   <= csr_data[MODE_W-1:0];
            CSR_NUM_BLOCKS: num_blocks_ff <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign new_cap       = best_ff - amt_ff;
   assign load_in_range = (int'(req_block_index) < MAX_BLOCKS);

   // single write port shared by capacity loads and the post-grant write back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pick_ff;
      wr_data = new_cap;
      if (cmd.load_wr) begin
         wr_en   = load_in_range;
         wr_addr = ADDR_W'(req_block_index);
         wr_data = SIZE_BITS'(req_amount);
      end else if (cmd.finish) begin
         wr_en = found_ff;
      end
   end

   // compare stage works on the entry read in the previous cycle
   assign fits = (rd_data >= amt_ff);
   always_comb begin
      take = 1'b0;
      if (cmp_vld_ff && fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (fit_mode_ff == FIT_BEST) begin
            take = (rd_data < best_ff);
         end else if (fit_mode_ff == FIT_WORST) begin
            take = (rd_data > best_ff);
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      rd_cnt_in  = rd_cnt_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      amt_in     = amt_ff;
      found_in   = found_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_cnt_ff[ADDR_W-1:0];

      if (cmd.start) begin
         count_in  = (int'(num_blocks_ff) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                        : CNT_W'(num_blocks_ff);
         rd_cnt_in = '0;
         amt_in    = SIZE_BITS'(req_amount);
         found_in  = 1'b0;
      end else if (cmd.scan) begin
         if (rd_cnt_ff < count_ff) begin
            rd_en      = 1'b1;
            rd_cnt_in  = rd_cnt_ff + 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = rd_cnt_ff[ADDR_W-1:0];
         end
         if (take) begin
            found_in = 1'b1;
            pick_in  = cmp_idx_ff;
            best_in  = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         rd_cnt_ff  <= '0;
         count_ff   <= '0;
      end else begin
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         rd_cnt_ff  <= rd_cnt_in;
         count_ff   <= count_in;
      end
      cmp_idx_ff <= cmp_idx_in;
      amt_ff     <= amt_in;
      pick_ff    <= pick_in;
      best_ff    <= best_in;
   end

   assign sts.scan_done = (rd_cnt_ff == count_ff) && !cmp_vld_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) begin
         rsp_granted_ff <= found_ff;
         rsp_index_ff   <= found_ff ? INDEX_W'(pick_ff) : '0;
         rsp_cap_ff     <= found_ff ? AMOUNT_W'(new_cap) : '0;
      end
   end

   pfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_chosen_index  = rsp_index_ff;
   assign rsp_capacity_left = rsp_cap_ff;

endmodule

/* sv/partition_fit_allocator.sv */
// Load request: writes the table when accepted, gives no response.
// Allocation request: scans the active blocks (block count, capped at MAX_BLOCKS) with
//   one table read per cycle, then writes back and responds; no request is taken meanwhile.
// A stalled response holds the following allocation before its write back.
// Synchronous active-high reset clears the controller, the response valid flag and
//   the mode/count registers; the capacity table is not cleared and must be loaded.
module partition_fit_allocator #(
   parameter int MAX_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   pfa_req_if.sink                        req,
   pfa_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0] csr_data
);
   import pfa_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;
   logic        req_ready;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_block_index   (req.block_index),
      .req_amount        (req.amount),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_granted       (rsp.granted),
      .rsp_chosen_index  (rsp.chosen_index),
      .rsp_capacity_left (rsp.capacity_left)
   );

   assign req.ready = req_ready;

endmodule

/* sv/pfa_checker.sv */
module pfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [pfa_pkg::KIND_W-1:0]      req_kind,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_granted,
   input logic [pfa_pkg::INDEX_W-1:0]     rsp_chosen_index,
   input logic [pfa_pkg::AMOUNT_W-1:0]    rsp_capacity_left
);
   import pfa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_granted) && $stable(rsp_chosen_index) && $stable(rsp_capacity_left))
      else $error("response payload changed while stalled");

   a_deny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_chosen_index == '0 && rsp_capacity_left == '0)
      else $error("denied response carries nonzero fields");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load request produced a response");

   a_alloc_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_ALLOC |=> !req_ready)
      else $error("request taken during allocation scan");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .req_kind          (req.kind),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_granted       (rsp.granted),
   .rsp_chosen_index  (rsp.chosen_index),
   .rsp_capacity_left (rsp.capacity_left)
);
